@@ sv/bpa_pkg.sv @@
// Shared widths, codes and sequencer states of the bitmap page allocator.
package bpa_pkg;

	localparam int KIND_W  = 2;
	localparam int IDX_W   = 16;
	localparam int CNT_W   = 17;
	localparam int CFG_A_W = 2;

	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REINIT = 2'd2;

	localparam logic [CFG_A_W-1:0] REG_TOTAL_PAGES  = 2'd0;
	localparam logic [CFG_A_W-1:0] REG_RESERVED_LOW = 2'd1;

	localparam logic [CNT_W-1:0] RESERVED_LOW_RESET = 17'd512;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_BIT,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_FREE_SEEK,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_FILL,
		ST_FINISH
	} state_t;

endpackage

@@ sv/bpa_bitmap_ram.sv @@
// Bitmap word memory: one write port, one registered read port.
module bpa_bitmap_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/bpa_word_unit.sv @@
// Page-range mask of one bitmap word and the count of set bits under it.
module bpa_word_unit #(
	parameter int WB  = 64,
	parameter int PGW = 18,
	parameter int CW  = 7
) (
	input  logic [PGW-1:0] base,
	input  logic [PGW-1:0] lo,
	input  logic [PGW-1:0] hi,
	input  logic [WB-1:0]  data,
	output logic [WB-1:0]  mask,
	output logic [CW-1:0]  hits
);

	logic [PGW-1:0] lo_d;
	logic [PGW-1:0] hi_d;
	logic [CW-1:0]  lo_off;
	logic [CW-1:0]  hi_off;
	logic [WB-1:0]  ones;

	assign ones = {WB{1'b1}};
	assign lo_d = lo - base;
	assign hi_d = hi - base;

	always_comb begin
		if (lo <= base) begin
			lo_off = '0;
		end else if (lo_d >= PGW'(WB)) begin
			lo_off = CW'(WB);
		end else begin
			lo_off = lo_d[CW-1:0];
		end
		if (hi <= base) begin
			hi_off = '0;
		end else if (hi_d >= PGW'(WB)) begin
			hi_off = CW'(WB);
		end else begin
			hi_off = hi_d[CW-1:0];
		end
	end

	assign mask = (ones << lo_off) & ~(ones << hi_off);
	assign hits = CW'($countones(data & mask));

endmodule

@@ sv/bitmap_page_allocator_top.sv @@
// Top level of the first-fit bitmap page allocator with its sequencer.
//
// One item at a time: busy is high from the accepting edge until the result
// beat, which shows on done for exactly one cycle and cannot be held off.
// Allocate walks the bitmap memory from page 0: a word wholly inside the
// managed total that is all used or all free is passed over whole, a mixed
// word is read and then examined page by page, and marking the run does a
// read-modify-write per word touched; latency therefore follows occupancy.
// Free steps word by word up to the first word of the run, then does a
// read-modify-write per word. Reinitialise writes every bitmap word, one a
// cycle (PAGE_COUNT_MAX/WORD_BITS words, 1024 at the defaults). After reset
// a like sweep sets every word to reserved with busy high; configuration
// writes are taken at any time, cfg_ready is always high.
module bitmap_page_allocator_top #(
	parameter int PAGE_COUNT_MAX = 65536,
	parameter int WORD_BITS      = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [bpa_pkg::KIND_W-1:0]   kind,
	input  logic [bpa_pkg::IDX_W-1:0]    page_index,
	input  logic [bpa_pkg::CNT_W-1:0]    page_count,
	output logic                         done,
	output logic                         ok,
	output logic [bpa_pkg::IDX_W-1:0]    run_start,
	output logic [bpa_pkg::CNT_W-1:0]    pages_changed,
	output logic [bpa_pkg::CNT_W-1:0]    free_pages,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bpa_pkg::CFG_A_W-1:0]  cfg_index,
	input  logic [bpa_pkg::CNT_W-1:0]    cfg_data
);

	import bpa_pkg::*;

	localparam int MAP_WORDS = (PAGE_COUNT_MAX + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int CW        = $clog2(WORD_BITS + 1);
	localparam int PGW_A     = $clog2(PAGE_COUNT_MAX + 2 * WORD_BITS) + 1;
	localparam int PGW       = (PGW_A > 18) ? PGW_A : 18;

	localparam logic [AW-1:0]  W_LAST   = AW'(MAP_WORDS - 1);
	localparam logic [BW-1:0]  B_LAST   = BW'(WORD_BITS - 1);
	localparam logic [PGW-1:0] WB_P     = PGW'(WORD_BITS);
	localparam logic [PGW-1:0] PCM_P    = PGW'(PAGE_COUNT_MAX);

	state_t state_q, state_d;

	logic [CNT_W-1:0]     total_q, res_q, used_q, cnt_q, run_q;
	logic [CNT_W-1:0]     changed_q, free_q;
	logic [IDX_W-1:0]     start_q;
	logic                 ok_q, done_q;
	logic [PGW-1:0]       lo_q, hi_q, base_q, first_q, fb_q;
	logic [AW-1:0]        w_q, fw_q;
	logic [BW-1:0]        bit_q;

	logic [CNT_W-1:0]     t_eff, res_eff, r_init;
	logic [CNT_W:0]       free_sum, alloc_sum;
	logic [PGW-1:0]       free_hi;
	logic                 alloc_ok, free_any;

	logic [PGW-1:0]       base_nx, p_cur;
	logic                 p_ge_t, whole, range_end, seek_skip;
	logic                 all1, all0, cur_bit, skip1, skip0, found, take_first;
	logic [CNT_W:0]       run_w, run_1;
	logic [PGW-1:0]       first_nx, fb_nx;
	logic [AW-1:0]        fw_nx;

	logic                 ram_we, ram_re;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata, wmask;
	logic [CW-1:0]        hits;
	logic [CNT_W-1:0]     chg_tot;

	bpa_bitmap_ram #(
		.DEPTH(MAP_WORDS),
		.WIDTH(WORD_BITS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(w_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(w_q),
		.rdata(ram_rdata)
	);

	bpa_word_unit #(
		.WB (WORD_BITS),
		.PGW(PGW),
		.CW (CW)
	) u_word (
		.base(base_q),
		.lo  (lo_q),
		.hi  (hi_q),
		.data(ram_rdata),
		.mask(wmask),
		.hits(hits)
	);

	always_comb begin
		t_eff     = (PGW'(total_q) > PCM_P) ? CNT_W'(PAGE_COUNT_MAX) : total_q;
		res_eff   = (res_q > t_eff) ? t_eff : res_q;
		if (t_eff == '0) begin
			r_init = '0;
		end else if (res_eff == '0) begin
			r_init = CNT_W'(1);
		end else begin
			r_init = res_eff;
		end
		free_sum  = (CNT_W + 1)'(page_index) + (CNT_W + 1)'(page_count);
		free_hi   = (free_sum > (CNT_W + 1)'(t_eff)) ? PGW'(t_eff) : PGW'(free_sum);
		free_any  = PGW'(page_index) < free_hi;
		alloc_sum = (CNT_W + 1)'(used_q) + (CNT_W + 1)'(page_count);
		alloc_ok  = (page_count != '0) && (alloc_sum <= (CNT_W + 1)'(t_eff));
	end

	always_comb begin
		base_nx    = base_q + WB_P;
		p_cur      = base_q + PGW'(bit_q);
		p_ge_t     = p_cur >= PGW'(t_eff);
		whole      = base_nx <= PGW'(t_eff);
		range_end  = base_nx >= hi_q;
		seek_skip  = base_nx <= lo_q;
		all1       = &ram_rdata;
		all0       = ~|ram_rdata;
		cur_bit    = ram_rdata[bit_q];
		skip1      = (bit_q == '0) && whole && all1;
		skip0      = (bit_q == '0) && whole && all0;
		run_w      = (CNT_W + 1)'(run_q) + (CNT_W + 1)'(WORD_BITS);
		run_1      = (CNT_W + 1)'(run_q) + (CNT_W + 1)'(1);
		if (skip1) begin
			found = 1'b0;
		end else if (skip0) begin
			found = run_w >= (CNT_W + 1)'(cnt_q);
		end else begin
			found = !cur_bit && (run_1 == (CNT_W + 1)'(cnt_q));
		end
		take_first = !skip1 && (skip0 || !cur_bit) && (run_q == '0);
		first_nx   = take_first ? (skip0 ? base_q : p_cur) : first_q;
		fw_nx      = take_first ? w_q : fw_q;
		fb_nx      = take_first ? base_q : fb_q;
		chg_tot    = changed_q + CNT_W'(hits);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (w_q == W_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (kind)
						KIND_ALLOC:  state_d = alloc_ok ? ST_SCAN_RD : ST_FINISH;
						KIND_FREE:   state_d = free_any ? ST_FREE_SEEK : ST_FINISH;
						KIND_REINIT: state_d = ST_FILL;
						default:     state_d = ST_FINISH;
					endcase
				end
			end
			ST_SCAN_RD: begin
				state_d = p_ge_t ? ST_FINISH : ST_SCAN_BIT;
			end
			ST_SCAN_BIT: begin
				if (p_ge_t) begin
					state_d = ST_FINISH;
				end else if (found) begin
					state_d = ST_MARK_RD;
				end else if (skip1 || skip0 || bit_q == B_LAST) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_MARK_RD: state_d = ST_MARK_WR;
			ST_MARK_WR: state_d = range_end ? ST_FINISH : ST_MARK_RD;
			ST_FREE_SEEK: begin
				if (!seek_skip) state_d = ST_FREE_RD;
			end
			ST_FREE_RD: state_d = ST_FREE_WR;
			ST_FREE_WR: state_d = range_end ? ST_FINISH : ST_FREE_RD;
			ST_FILL: begin
				if (w_q == W_LAST) state_d = ST_FINISH;
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_wdata = ~wmask;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = '1;
			end
			ST_SCAN_RD: ram_re = !p_ge_t;
			ST_MARK_RD: ram_re = 1'b1;
			ST_FREE_RD: ram_re = 1'b1;
			ST_MARK_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata | wmask;
			end
			ST_FREE_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata & ~wmask;
			end
			ST_FILL: ram_we = 1'b1;
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			total_q <= '0;
			res_q   <= RESERVED_LOW_RESET;
			used_q  <= '0;
			done_q  <= 1'b0;
			w_q     <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TOTAL_PAGES:  total_q <= cfg_data;
					REG_RESERVED_LOW: res_q   <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_INIT: begin
					w_q <= w_q + AW'(1);
				end
				ST_IDLE: begin
					if (start) begin
						cnt_q     <= page_count;
						ok_q      <= 1'b0;
						start_q   <= '0;
						changed_q <= '0;
						w_q       <= '0;
						base_q    <= '0;
						bit_q     <= '0;
						run_q     <= '0;
						case (kind)
							KIND_FREE: begin
								lo_q <= PGW'(page_index);
								hi_q <= free_hi;
								ok_q <= 1'b1;
							end
							KIND_REINIT: begin
								lo_q      <= PGW'(r_init);
								hi_q      <= PGW'(t_eff);
								used_q    <= r_init;
								changed_q <= r_init;
								ok_q      <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN_BIT: begin
					if (!p_ge_t) begin
						if (take_first) begin
							first_q <= first_nx;
							fw_q    <= fw_nx;
							fb_q    <= fb_nx;
						end
						if (found) begin
							lo_q   <= first_nx;
							hi_q   <= first_nx + PGW'(cnt_q);
							w_q    <= fw_nx;
							base_q <= fb_nx;
						end else if (skip1) begin
							run_q  <= '0;
							w_q    <= w_q + AW'(1);
							base_q <= base_nx;
							bit_q  <= '0;
						end else if (skip0) begin
							run_q  <= CNT_W'(run_w);
							w_q    <= w_q + AW'(1);
							base_q <= base_nx;
							bit_q  <= '0;
						end else begin
							run_q <= cur_bit ? '0 : CNT_W'(run_1);
							if (bit_q == B_LAST) begin
								w_q    <= w_q + AW'(1);
								base_q <= base_nx;
								bit_q  <= '0;
							end else begin
								bit_q <= bit_q + BW'(1);
							end
						end
					end
				end
				ST_MARK_WR: begin
					if (range_end) begin
						used_q    <= used_q + cnt_q;
						ok_q      <= 1'b1;
						start_q   <= first_q[IDX_W-1:0];
						changed_q <= cnt_q;
					end else begin
						w_q    <= w_q + AW'(1);
						base_q <= base_nx;
					end
				end
				ST_FREE_SEEK: begin
					if (seek_skip) begin
						w_q    <= w_q + AW'(1);
						base_q <= base_nx;
					end
				end
				ST_FREE_WR: begin
					changed_q <= chg_tot;
					if (range_end) begin
						used_q <= (used_q >= chg_tot) ? used_q - chg_tot : '0;
					end else begin
						w_q    <= w_q + AW'(1);
						base_q <= base_nx;
					end
				end
				ST_FILL: begin
					w_q    <= w_q + AW'(1);
					base_q <= base_nx;
				end
				ST_FINISH: begin
					done_q <= 1'b1;
					free_q <= (used_q >= t_eff) ? '0 : t_eff - used_q;
				end
				default: ;
			endcase
		end
	end

	assign busy          = state_q != ST_IDLE;
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign ok            = ok_q;
	assign run_start     = start_q;
	assign pages_changed = changed_q;
	assign free_pages    = free_q;

endmodule

@@ sv/bpa_checker.sv @@
// Port-level checks of the page allocator and their bind to the top level.
module bpa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         ok,
	input logic [bpa_pkg::IDX_W-1:0]    run_start,
	input logic [bpa_pkg::CNT_W-1:0]    pages_changed
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted beat did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (run_start == '0 && pages_changed == '0))
		else $error("failed beat carries a run");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the first-fit bitmap page allocator.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bpa_pkg::*;

	localparam int PAGE_MAX    = 65536;
	localparam int RAND_ITEMS  = 360;
	localparam int IDLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES = 2200;

	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] run_start;
		logic [CNT_W-1:0] pages_changed;
		logic [CNT_W-1:0] free_pages;
	} alloc_result_t;

	typedef struct packed {
		bit                 is_cfg;
		logic [CFG_A_W-1:0] cfg_idx;
		logic [CNT_W-1:0]   cfg_val;
		logic [KIND_W-1:0]  kind;
		logic [IDX_W-1:0]   page_index;
		logic [CNT_W-1:0]   page_count;
		bit                 typed;
		alloc_result_t      result;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [KIND_W-1:0]  kind = '0;
	logic [IDX_W-1:0]   page_index = '0;
	logic [CNT_W-1:0]   page_count = '0;
	logic               done;
	logic               ok;
	logic [IDX_W-1:0]   run_start;
	logic [CNT_W-1:0]   pages_changed;
	logic [CNT_W-1:0]   free_pages;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_A_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0]   cfg_data = '0;

	bit            page_map [PAGE_MAX];
	int            used_pages;
	logic [CNT_W-1:0] cfg_total;
	logic [CNT_W-1:0] cfg_reserved;

	alloc_result_t pending_results [$];
	stim_row_t     dir_rows [$];
	int            mismatch_count = 0;
	int            burst_left = 0;
	int            idle_cycles = 0;

	bitmap_page_allocator_top u_top (.*);

	always #5 clk = ~clk;

	function automatic int eff_total();
		return (int'(cfg_total) > PAGE_MAX) ? PAGE_MAX : int'(cfg_total);
	endfunction

	function automatic alloc_result_t predict_request(logic [KIND_W-1:0] k,
			logic [IDX_W-1:0] pi, logic [CNT_W-1:0] pc);
		alloc_result_t r;
		int lim;
		int n;
		int run;
		int first;
		int cur;
		int changed;
		int keep;
		r = '0;
		lim = eff_total();
		n = int'(pc);
		changed = 0;
		case (k)
			KIND_ALLOC: begin
				if (n != 0 && used_pages + n <= lim) begin
					run = 0;
					first = 0;
					for (int i = 0; i < lim; i++) begin
						if (!page_map[i]) begin
							if (run == 0)
								first = i;
							run++;
							if (run == n)
								break;
						end else begin
							run = 0;
						end
					end
					if (run == n) begin
						for (int i = 0; i < n; i++)
							page_map[first + i] = 1'b1;
						used_pages = (used_pages + n) & 32'h1FFFF;
						r.ok = 1'b1;
						r.run_start = 16'(first);
						r.pages_changed = pc;
					end
				end
			end
			KIND_FREE: begin
				for (int i = 0; i < n; i++) begin
					cur = int'(pi) + i;
					if (cur >= lim)
						break;
					if (page_map[cur]) begin
						page_map[cur] = 1'b0;
						if (used_pages > 0)
							used_pages--;
						changed++;
					end
				end
				r.ok = 1'b1;
				r.pages_changed = 17'(changed);
			end
			KIND_REINIT: begin
				for (int i = 0; i < PAGE_MAX; i++)
					page_map[i] = (i >= lim);
				used_pages = 0;
				if (lim > 0) begin
					page_map[0] = 1'b1;
					used_pages = 1;
				end
				keep = (int'(cfg_reserved) > lim) ? lim : int'(cfg_reserved);
				for (int i = 1; i < keep; i++) begin
					if (!page_map[i]) begin
						page_map[i] = 1'b1;
						used_pages++;
					end
				end
				r.ok = 1'b1;
				r.pages_changed = 17'(used_pages);
			end
			default: begin
			end
		endcase
		r.free_pages = (used_pages >= lim) ? '0 : 17'(lim - used_pages);
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_A_W-1:0] ri, logic [CNT_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.cfg_idx = ri;
		r.cfg_val = val;
		return r;
	endfunction

	function automatic stim_row_t req_row(logic [KIND_W-1:0] k, logic [IDX_W-1:0] pi,
			logic [CNT_W-1:0] pc);
		stim_row_t r;
		r = '0;
		r.kind = k;
		r.page_index = pi;
		r.page_count = pc;
		return r;
	endfunction

	function automatic stim_row_t req_chk(logic [KIND_W-1:0] k, logic [IDX_W-1:0] pi,
			logic [CNT_W-1:0] pc, logic ok_v, logic [IDX_W-1:0] sp,
			logic [CNT_W-1:0] chg, logic [CNT_W-1:0] fp);
		stim_row_t r;
		r = req_row(k, pi, pc);
		r.typed = 1'b1;
		r.result = '{ok: ok_v, run_start: sp, pages_changed: chg, free_pages: fp};
		return r;
	endfunction

	task automatic send_request(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] pi,
			input logic [CNT_W-1:0] pc, input bit typed, input alloc_result_t typed_res);
		alloc_result_t want;
		start <= 1'b1;
		kind <= k;
		page_index <= pi;
		page_count <= pc;
		do @(posedge clk); while (busy !== 1'b0);
		want = predict_request(k, pi, pc);
		pending_results.push_back(typed ? typed_res : want);
	endtask

	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 30 : int'($urandom_range(0, 7));
		end
	endtask

	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_A_W-1:0] ri, input logic [CNT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (ri == REG_TOTAL_PAGES)
			cfg_total = val;
		else if (ri == REG_RESERVED_LOW)
			cfg_reserved = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : result_monitor
		alloc_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, got ok=%0d start=%0d",
					$time, ok, run_start);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("ok", 17'(want.ok), 17'(ok));
				check_field("run_start", 17'(want.run_start), 17'(run_start));
				check_field("pages_changed", want.pages_changed, pages_changed);
				check_field("free_pages", want.free_pages, free_pages);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int lim;
		int n_items;
		int rand_sent;
		int tsel;
		int rsel;
		int ksel;
		int csel;
		logic [CNT_W-1:0]  tval;
		logic [CNT_W-1:0]  rval;
		logic [CNT_W-1:0]  pc;
		logic [IDX_W-1:0]  pi;
		logic [KIND_W-1:0] k;

		for (int i = 0; i < PAGE_MAX; i++)
			page_map[i] = 1'b1;
		used_pages = 0;
		cfg_total = '0;
		cfg_reserved = RESERVED_LOW_RESET;

		dir_rows.push_back(req_chk(KIND_ALLOC, 16'd0, 17'd1, 1'b0, 16'd0, 17'd0, 17'd0));
		dir_rows.push_back(req_chk(KIND_FREE, 16'd0, 17'd5, 1'b1, 16'd0, 17'd0, 17'd0));
		dir_rows.push_back(req_chk(KIND_REINIT, 16'd0, 17'd0, 1'b1, 16'd0, 17'd0, 17'd0));
		dir_rows.push_back(req_chk(KIND_UNKNOWN, 16'd0, 17'd0, 1'b0, 16'd0, 17'd0, 17'd0));
		dir_rows.push_back(cfg_row(REG_TOTAL_PAGES, 17'd200));
		dir_rows.push_back(cfg_row(REG_RESERVED_LOW, 17'd16));
		dir_rows.push_back(req_chk(KIND_REINIT, 16'd0, 17'd0, 1'b1, 16'd0, 17'd16, 17'd184));
		dir_rows.push_back(req_chk(KIND_ALLOC, 16'd0, 17'd0, 1'b0, 16'd0, 17'd0, 17'd184));
		dir_rows.push_back(req_chk(KIND_ALLOC, 16'd0, 17'd1, 1'b1, 16'd16, 17'd1, 17'd183));
		dir_rows.push_back(req_chk(KIND_ALLOC, 16'd0, 17'd184, 1'b0, 16'd0, 17'd0, 17'd183));
		dir_rows.push_back(req_chk(KIND_ALLOC, 16'd0, 17'd183, 1'b1, 16'd17, 17'd183, 17'd0));
		dir_rows.push_back(req_row(KIND_FREE, 16'd150, 17'h1FFFF));
		dir_rows.push_back(req_row(KIND_FREE, 16'hFFFF, 17'd10));
		dir_rows.push_back(req_row(KIND_ALLOC, 16'hFFFF, 17'd20));
		dir_rows.push_back(req_row(KIND_FREE, 16'd0, 17'd3));
		dir_rows.push_back(req_row(KIND_UNKNOWN, 16'd1234, 17'd77));
		dir_rows.push_back(cfg_row(REG_RESERVED_LOW, 17'd300));
		dir_rows.push_back(req_chk(KIND_REINIT, 16'd0, 17'd0, 1'b1, 16'd0, 17'd200, 17'd0));
		dir_rows.push_back(cfg_row(REG_TOTAL_PAGES, 17'd1));
		dir_rows.push_back(cfg_row(REG_RESERVED_LOW, 17'd0));
		dir_rows.push_back(req_chk(KIND_REINIT, 16'd0, 17'd0, 1'b1, 16'd0, 17'd1, 17'd0));
		dir_rows.push_back(req_chk(KIND_ALLOC, 16'd0, 17'd1, 1'b0, 16'd0, 17'd0, 17'd0));
		dir_rows.push_back(cfg_row(REG_TOTAL_PAGES, 17'd400));
		dir_rows.push_back(req_row(KIND_ALLOC, 16'd0, 17'd1));
		dir_rows.push_back(req_row(KIND_FREE, 16'd100, 17'd50));
		dir_rows.push_back(req_row(KIND_ALLOC, 16'd0, 17'd50));
		dir_rows.push_back(cfg_row(REG_TOTAL_PAGES, 17'h1FFFF));
		dir_rows.push_back(cfg_row(REG_RESERVED_LOW, 17'h1FFFF));
		dir_rows.push_back(req_chk(KIND_REINIT, 16'd0, 17'd0, 1'b1, 16'd0, 17'd65536, 17'd0));
		dir_rows.push_back(cfg_row(REG_RESERVED_LOW, 17'd0));
		dir_rows.push_back(req_chk(KIND_REINIT, 16'd0, 17'd0, 1'b1, 16'd0, 17'd1, 17'd65535));
		dir_rows.push_back(req_chk(KIND_ALLOC, 16'd0, 17'd65536, 1'b0, 16'd0, 17'd0,
			17'd65535));
		dir_rows.push_back(req_chk(KIND_ALLOC, 16'd0, 17'd65535, 1'b1, 16'd1, 17'd65535,
			17'd0));
		dir_rows.push_back(req_chk(KIND_FREE, 16'd0, 17'd65536, 1'b1, 16'd0, 17'd65536,
			17'd65536));
		dir_rows.push_back(req_chk(KIND_ALLOC, 16'd0, 17'd65536, 1'b1, 16'd0, 17'd65536,
			17'd0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		quiesce();

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				quiesce();
				write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
			end else begin
				send_request(dir_rows[i].kind, dir_rows[i].page_index, dir_rows[i].page_count,
					dir_rows[i].typed, dir_rows[i].result);
				pace_sender();
			end
		end

		rand_sent = 0;
		while (rand_sent < RAND_ITEMS) begin
			quiesce();
			tsel = $urandom_range(0, 19);
			case (tsel)
				0: tval = 17'd0;
				1: tval = 17'd1;
				2: tval = 17'd65536;
				3: tval = 17'h1FFFF;
				4: tval = 17'($urandom_range(601, 65536));
				default: tval = 17'($urandom_range(2, 600));
			endcase
			write_reg(REG_TOTAL_PAGES, tval);
			lim = eff_total();
			rsel = $urandom_range(0, 9);
			case (rsel)
				0: rval = 17'd0;
				1: rval = 17'd1;
				2: rval = 17'h1FFFF;
				3: rval = 17'(lim + int'($urandom_range(0, 5)));
				default: rval = 17'($urandom_range(0, lim / 2));
			endcase
			write_reg(REG_RESERVED_LOW, rval);

			if ($urandom_range(0, 3) != 0) begin
				send_request(KIND_REINIT, 16'($urandom), 17'($urandom), 1'b0, '0);
				pace_sender();
				rand_sent++;
			end

			n_items = $urandom_range(20, 45);
			repeat (n_items) begin
				ksel = $urandom_range(0, 99);
				if (ksel < 48)
					k = KIND_ALLOC;
				else if (ksel < 88)
					k = KIND_FREE;
				else if (ksel < 95)
					k = KIND_REINIT;
				else
					k = KIND_UNKNOWN;
				csel = $urandom_range(0, 9);
				if (csel < 7)
					pc = 17'($urandom_range(1, (lim / 8 > 1) ? lim / 8 : 1));
				else if (csel == 7)
					pc = 17'd0;
				else if (csel == 8)
					pc = 17'($urandom_range(0, lim + 2));
				else
					pc = 17'($urandom);
				if ($urandom_range(0, 4) != 0)
					pi = 16'($urandom_range(0, (lim > 0) ? lim - 1 : 0));
				else
					pi = 16'($urandom);
				send_request(k, pi, pc, 1'b0, '0);
				pace_sender();
				rand_sent++;
			end
		end

		quiesce();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
